FILE: hdl/tfr_pkg.sv
`timescale 1ns / 1ps
package tfr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

    localparam logic [7:0]  MIN_FRAME = 8'd10;
    localparam logic [7:0]  TOUCH_LEN = 8'h07;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
    localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;
    localparam logic [7:0] TOUCH_CMD_RST     = 8'h41;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_TOUCH_COMMAND = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_HEADER    = 3'd2,
        ST_LENGTH    = 3'd3,
        ST_COMMAND   = 3'd4,
        ST_CRC       = 3'd5
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [3:0][7:0]      first;
        logic [5:0][7:0]      field;
        logic [15:0]          crc;
    } t_frame;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] touch_command;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        event_valid;
        logic [15:0] key_address;
        logic [15:0] key_code;
    } t_result;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/tfr_frame_acc.sv
`timescale 1ns / 1ps
module tfr_frame_acc
    import tfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    output t_frame     o_frame,
    output logic       o_close
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0][7:0]  r_first, n_first;
    logic [5:0][7:0]  r_field, n_field;
    logic [15:0]      r_crc, n_crc;
    logic [CNT_W-1:0] pos_m4;

    always_comb begin
        n_first = r_first;
        n_field = r_field;
        n_crc   = r_crc;
        pos_m4  = r_count - CNT_W'(4);
        if (r_count < CNT_W'(4)) begin
            n_first[r_count[1:0]] = i_rx_byte;
        end else if (r_count < CNT_W'(10)) begin
            n_field[pos_m4[2:0]] = i_rx_byte;
        end
        // crc covers the command byte through the key value
        if (r_count >= CNT_W'(3) && r_count <= CNT_W'(7)) begin
            n_crc = crc16_byte(r_crc, i_rx_byte);
        end
        n_count = r_count + CNT_W'(1);
        o_close = i_end_of_frame || (n_count == CNT_W'(BUFFER_BYTES));
        o_frame = '{count: n_count, first: n_first, field: n_field, crc: n_crc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
            r_field <= '0;
            r_crc   <= CRC_INIT;
        end else if (i_accept) begin
            if (o_close) begin
                r_count <= '0;
                r_first <= '0;
                r_field <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                r_count <= n_count;
                r_first <= n_first;
                r_field <= n_field;
                r_crc   <= n_crc;
            end
        end
    end

endmodule

FILE: hdl/tfr_check.sv
`timescale 1ns / 1ps
module tfr_check
    import tfr_pkg::*;
(
    input  t_frame  i_frame,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [8:0]  expect_cnt;
    logic [15:0] crc_rx;

    always_comb begin
        expect_cnt = 9'd3 + {1'b0, i_frame.first[2]};
        crc_rx     = {i_frame.field[5], i_frame.field[4]};
        o_result   = '{status: ST_OK, event_valid: 1'b0,
                       key_address: 16'h0000, key_code: 16'h0000};
        if ({{(9 - CNT_W){1'b0}}, i_frame.count} < {1'b0, MIN_FRAME}) begin
            o_result.status = ST_SHORT;
        end else if (i_frame.first[0] != i_cfg.header_first ||
                     i_frame.first[1] != i_cfg.header_second) begin
            o_result.status = ST_HEADER;
        end else if ({{(9 - CNT_W){1'b0}}, i_frame.count} != expect_cnt) begin
            o_result.status = ST_LENGTH;
        end else if (i_frame.first[2] != TOUCH_LEN ||
                     i_frame.first[3] != i_cfg.touch_command) begin
            o_result.status = ST_COMMAND;
        end else if (i_frame.crc != crc_rx) begin
            o_result.status = ST_CRC;
        end else begin
            o_result.status      = ST_OK;
            o_result.event_valid = 1'b1;
            o_result.key_address = {i_frame.field[0], i_frame.field[1]};
            o_result.key_code    = {i_frame.field[2], i_frame.field[3]};
        end
    end

endmodule

FILE: hdl/touch_frame_receiver_crc_check.sv
`timescale 1ns / 1ps
// a frame's result word is valid in the cycle after its closing byte is taken
// throughput: one byte per cycle unless stalled; the byte accumulator and crc update
// are combinational; input stalls only while a result word waits in the output
// register and is stalled; reset (synchronous, active low) empties the frame,
// sets crc to FFFF, loads the default header and command bytes and drops output valid
module touch_frame_receiver_crc_check
    import tfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_event_valid,
    output logic [15:0] o_key_address,
    output logic [15:0] o_key_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_frame  frame;
    logic    close;
    logic    in_accept;
    t_result result;
    t_result r_result;
    logic    r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{header_first: HEADER_FIRST_RST,
                       header_second: HEADER_SECOND_RST,
                       touch_command: TOUCH_CMD_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_data;
                REG_HEADER_SECOND: r_cfg.header_second <= i_cfg_data;
                REG_TOUCH_COMMAND: r_cfg.touch_command <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tfr_frame_acc u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_frame        (frame),
        .o_close        (close)
    );

    tfr_check u_check (
        .i_frame  (frame),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && close) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && close) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_event_valid = r_result.event_valid;
    assign o_key_address = r_result.key_address;
    assign o_key_code    = r_result.key_code;

`ifndef NO_ASSERTIONS
    a_event_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_valid == (o_status == ST_OK)))
        else $error("event flag disagrees with status");

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_event_valid) |-> (o_key_address == 16'h0000 &&
                                             o_key_code == 16'h0000))
        else $error("rejected frame carries key data");

    a_status_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_CRC))
        else $error("status code out of range");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");
`endif

endmodule
